FILE: hdl/dat_pkg.sv
// Package for the descriptor address translator.
// Holds payload types, codes and constants; no dependencies.
`timescale 1ns / 1ps
package dat_pkg;

  localparam int unsigned MaxDesc = 16;
  localparam int unsigned IdxW = $clog2(MaxDesc);

  typedef enum logic [2:0] {
    CON_OTHER = 3'd0, CON_NES = 3'd1, CON_GBC = 3'd2,
    CON_GBA = 3'd3, CON_PCE = 3'd4, CON_SNES = 3'd5
  } console_t;

  localparam logic [2:0] CFG_CONSOLE = 3'd0;
  localparam logic [2:0] CFG_COUNT = 3'd1;
  localparam logic [2:0] CFG_SYS = 3'd2;
  localparam logic [2:0] CFG_SAVE = 3'd3;
  localparam logic [2:0] CFG_VIDEO = 3'd4;
  localparam logic [2:0] CFG_CLOCK = 3'd5;

  localparam logic [2:0] FLD_BASE = 3'd0;
  localparam logic [2:0] FLD_SELECT = 3'd1;
  localparam logic [2:0] FLD_DISC = 3'd2;
  localparam logic [2:0] FLD_KEEP = 3'd3;
  localparam logic [2:0] FLD_LENGTH = 3'd4;
  localparam logic [2:0] FLD_OFFSET = 3'd5;
  localparam logic [2:0] FLD_BACKED = 3'd6;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] guest_address;
    logic [3:0]  entry_index;
    logic [2:0]  field_select;
    logic [31:0] field_value;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic        source_kind;
    logic [3:0]  region_index;
    logic [31:0] region_offset;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // latch input beat and remap address
    logic wr_field;   // write descriptor field
    logic rd_entry;   // register the scanned slot
    logic test_entry; // evaluate registered slot
    logic sq_start;   // start squeeze
    logic sq_step;    // one squeeze iteration
    logic finish_desc;
    logic fb_step;    // one fallback region test
    logic next_slot;
  } dat_cmd_t;

  typedef struct packed {
    logic is_write;
    logic use_fallback;
    logic match;      // registered slot matches
    logic scan_last;  // current slot is the last to scan
    logic sq_done;
    logic fb_hit;
    logic fb_last;
  } dat_sts_t;

endpackage

FILE: hdl/descriptor_address_translator.sv
// Top level of the descriptor address translator.
// Instantiates dat_ctrl and dat_datapath; depends on dat_pkg.
//
//  channel | direction | handshake        | beat payload
//  in_     | input     | in_valid/in_stall | in_beat_t
//  out_    | output    | out_valid/out_stall | out_beat_t
//  cfg_    | input     | cfg_valid/cfg_ready | index, data
//
// One item at a time. A write beat is decoded, written and the block is idle
// again. A translation is decoded, then reads and tests each descriptor in turn
// (up to 16), then squeezes one disconnect bit per step (up to 32) and closes on a
// match, or walks up to four fallback regions; the squeeze unit sets the
// worst case.
// The output register holds a result while out_stall is high; the next
// input beat is already taken then. Reset is synchronous, active low.
`timescale 1ns / 1ps
module descriptor_address_translator
  import dat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0]  console_kind_r;
  logic [4:0]  descriptor_count_r;
  logic [31:0] system_ram_size_r, save_ram_size_r, video_ram_size_r, clock_ram_size_r;

  dat_cmd_t  cmd;
  dat_sts_t  sts;
  out_beat_t result;
  logic      busy, done, in_go, out_free;
  logic      out_valid_r;
  out_beat_t out_beat_r;

  assign cfg_ready = 1'b1;
  // Configuration registers; the user must write them only while idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      console_kind_r <= '0;
      descriptor_count_r <= '0;
      system_ram_size_r <= '0;
      save_ram_size_r <= '0;
      video_ram_size_r <= '0;
      clock_ram_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONSOLE: console_kind_r <= cfg_data[2:0];
        CFG_COUNT:   descriptor_count_r <= cfg_data[4:0];
        CFG_SYS:     system_ram_size_r <= cfg_data;
        CFG_SAVE:    save_ram_size_r <= cfg_data;
        CFG_VIDEO:   video_ram_size_r <= cfg_data;
        CFG_CLOCK:   clock_ram_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unknown console codes behave as "other".
  logic [2:0] console_eff;
  assign console_eff = (console_kind_r > CON_SNES) ? CON_OTHER : console_kind_r;

  assign in_stall = busy;
  assign in_go = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  dat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_go(in_go), .sts(sts), .out_free(out_free),
    .cmd(cmd), .busy(busy), .done(done)
  );

  dat_datapath u_dp (
    .clk(clk), .in_beat(in_beat), .cmd(cmd), .console_kind(console_eff),
    .descriptor_count(descriptor_count_r), .system_ram_size(system_ram_size_r),
    .save_ram_size(save_ram_size_r), .video_ram_size(video_ram_size_r),
    .clock_ram_size(clock_ram_size_r), .sts(sts), .result(result)
  );

  // Output register: loaded when a result is done, cleared once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) out_beat_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_beat = out_beat_r;

  // A result is only loaded into a free output register.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free) else $error("result overwrote a pending beat");
  // A miss reports region zero and offset zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beat.found) |-> (out_beat.region_offset == 32'd0 &&
    out_beat.region_index == 4'd0)) else $error("miss with nonzero payload");
  // Fallback results never name a region above three.
  a_fb_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.source_kind) |-> (out_beat.region_index[3:2] == 2'b00))
    else $error("fallback region out of range");
  // No input is taken while an item is in progress.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall) else $error("input accepted while busy");

endmodule

FILE: hdl/dat_ctrl.sv
// Controller state machine of the descriptor address translator.
// Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_ctrl
  import dat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_go,
  input  dat_sts_t sts,
  input  logic     out_free,
  output dat_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DECODE = 7'b0000010, S_READ = 7'b0000100,
    S_TEST = 7'b0001000, S_SQZ = 7'b0010000, S_FB = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_go) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_write) begin
          cmd.wr_field = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.use_fallback) begin
          state_nxt = S_FB;
        end else begin
          cmd.rd_entry = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.test_entry = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sts.match) begin
          cmd.sq_start = 1'b1;
          state_nxt = S_SQZ;
        end else if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_slot = 1'b1;
          cmd.rd_entry = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_SQZ: begin
        if (sts.sq_done) begin
          cmd.finish_desc = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_FB: begin
        cmd.fb_step = 1'b1;
        if (sts.fb_hit || sts.fb_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hdl/dat_datapath.sv
// Datapath of the descriptor address translator: descriptor store,
// remap, match, bit squeeze and fallback walk. Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_datapath
  import dat_pkg::*;
(
  input  logic        clk,
  input  in_beat_t    in_beat,
  input  dat_cmd_t    cmd,
  input  logic [2:0]  console_kind,
  input  logic [4:0]  descriptor_count,
  input  logic [31:0] system_ram_size,
  input  logic [31:0] save_ram_size,
  input  logic [31:0] video_ram_size,
  input  logic [31:0] clock_ram_size,
  output dat_sts_t    sts,
  output out_beat_t   result
);

  logic [31:0] mem_base   [MaxDesc];
  logic [31:0] mem_sel    [MaxDesc];
  logic [31:0] mem_disc   [MaxDesc];
  logic [31:0] mem_keep   [MaxDesc];
  logic [31:0] mem_len    [MaxDesc];
  logic [31:0] mem_off    [MaxDesc];
  logic        mem_backed [MaxDesc];

  in_beat_t    beat_r;
  logic [31:0] addr_r, addr_nxt;
  logic [IdxW-1:0] slot_r;
  logic [31:0] e_base_r, e_sel_r, e_disc_r, e_keep_r, e_len_r, e_off_r;
  logic        e_backed_r;
  logic        match_r;
  logic [31:0] v_r, gaps_r, low_r;
  logic [1:0]  fb_r;
  out_beat_t   res_r;

  // Remap applied at load.
  always_comb begin
    logic [31:0] a;
    a = in_beat.guest_address;
    if (console_kind == CON_NES) begin
      if (a >= 32'h0800 && a < 32'h2000) a = a & 32'h07ff;
    end else if (console_kind == CON_GBC) begin
      if (a >= 32'he000 && a <= 32'hfdff) a = a - 32'h2000;
    end
    if (descriptor_count != 5'd0) begin
      case (console_kind)
        CON_GBA: a = a + ((a < 32'h8000) ? 32'h3000000 : (32'h2000000 - 32'h8000));
        CON_PCE: begin
          if (a < 32'h002000) a = a + 32'h1f0000;
          else if (a < 32'h012000) a = a + (32'h100000 - 32'h002000);
          else if (a < 32'h042000) a = a + (32'h0d0000 - 32'h012000);
          else a = a + (32'h1ee000 - 32'h042000);
        end
        CON_SNES: begin
          if (a < 32'h020000) a = a + 32'h7e0000;
          else a = a + (32'h006000 - 32'h020000);
        end
        default: ;
      endcase
    end
    addr_nxt = a;
  end

  logic [5:0] scan_n;
  assign scan_n = (descriptor_count > 5'(MaxDesc)) ? 6'(MaxDesc) : 6'(descriptor_count);

  logic [31:0] fb_size;
  always_comb begin
    case (fb_r)
      2'd0: fb_size = system_ram_size;
      2'd1: fb_size = save_ram_size;
      2'd2: fb_size = video_ram_size;
      default: fb_size = clock_ram_size;
    endcase
  end

  logic [31:0] gaps_low, top_v;
  assign gaps_low = (gaps_r - 32'd1) & ~gaps_r;
  always_comb begin
    logic [31:0] n;
    n = v_r;
    n = n | (n >> 1);
    n = n | (n >> 2);
    n = n | (n >> 4);
    n = n | (n >> 8);
    n = n | (n >> 16);
    top_v = n ^ (n >> 1);
  end
  logic [31:0] clamped;
  assign clamped = (v_r >= e_len_r) ? v_r - top_v : v_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      beat_r <= in_beat;
      addr_r <= addr_nxt;
      slot_r <= '0;
      fb_r <= 2'd0;
      res_r <= '{1'b0, (descriptor_count == 5'd0), 4'd0, 32'd0};
    end
    if (cmd.wr_field && ({1'b0, beat_r.entry_index} < 5'(MaxDesc))) begin
      case (beat_r.field_select)
        FLD_BASE:   mem_base[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_SELECT: mem_sel[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_DISC:   mem_disc[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_KEEP:   mem_keep[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_LENGTH: mem_len[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_OFFSET: mem_off[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value;
        FLD_BACKED: mem_backed[beat_r.entry_index[IdxW-1:0]] <= beat_r.field_value[0];
        default: ;
      endcase
    end
    if (cmd.next_slot) slot_r <= slot_r + 1'b1;
    if (cmd.rd_entry) begin
      e_base_r <= mem_base[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_sel_r <= mem_sel[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_disc_r <= mem_disc[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_keep_r <= mem_keep[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_len_r <= mem_len[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_off_r <= mem_off[cmd.next_slot ? slot_r + 1'b1 : slot_r];
      e_backed_r <= mem_backed[cmd.next_slot ? slot_r + 1'b1 : slot_r];
    end
    if (cmd.test_entry) match_r <= ((e_base_r ^ addr_r) & e_sel_r) == 32'd0;
    if (cmd.sq_start) begin
      v_r <= (addr_r - e_base_r) & e_keep_r;
      gaps_r <= e_disc_r;
    end
    if (cmd.sq_step) begin
      v_r <= (v_r & gaps_low) | ((v_r >> 1) & ~gaps_low);
      gaps_r <= (gaps_r & (gaps_r - 32'd1)) >> 1;
    end
    if (cmd.finish_desc && e_backed_r) begin
      res_r <= '{1'b1, res_r.source_kind, 4'(slot_r), clamped + e_off_r};
    end
    if (cmd.fb_step) begin
      if (addr_r < fb_size) begin
        res_r <= '{1'b1, res_r.source_kind, {2'b00, fb_r}, addr_r};
      end
      addr_r <= addr_r - ((fb_r == 2'd0 && console_kind == CON_NES) ? 32'h6000 : fb_size);
      fb_r <= fb_r + 2'd1;
    end
  end

  assign low_r = gaps_low;
  assign sts.is_write = (beat_r.opcode == OP_WRITE);
  assign sts.use_fallback = res_r.source_kind;
  assign sts.match = match_r;
  assign sts.scan_last = (6'(slot_r) + 6'd1 >= scan_n);
  assign sts.sq_done = (gaps_r == 32'd0) && (low_r == 32'hffff_ffff);
  assign sts.fb_hit = (addr_r < fb_size);
  assign sts.fb_last = (fb_r == 2'd3);
  assign result = res_r;

endmodule

FILE: tb/sv/dat_checker.sv
// Result checker for the descriptor address translator.
// Predicts translations from observed beats and config writes; depends on dat_pkg.
`timescale 1ns / 1ps
module dat_checker
  import dat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_beat,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_beat,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [2:0]  con_q;
  logic [4:0]  count_q;
  logic [31:0] size_q [4];
  logic [31:0] base_m [MaxDesc];
  logic [31:0] sel_m [MaxDesc];
  logic [31:0] disc_m [MaxDesc];
  logic [31:0] keep_m [MaxDesc];
  logic [31:0] len_m [MaxDesc];
  logic [31:0] offs_m [MaxDesc];
  logic        backed_m [MaxDesc];
  out_beat_t   translations_due [$];

  assign pending = translations_due.size();

  function automatic logic [31:0] squeeze(logic [31:0] v, logic [31:0] gaps);
    logic [31:0] low;
    while (gaps != 0) begin
      low = (gaps - 1) & ~gaps;
      v = (v & low) | ((v >> 1) & ~low);
      gaps = (gaps & (gaps - 1)) >> 1;
    end
    return v;
  endfunction

  function automatic logic [31:0] highest_bit(logic [31:0] n);
    for (int b = 31; b >= 0; b--) begin
      if (n[b]) return 32'd1 << b;
    end
    return 32'd0;
  endfunction

  function automatic out_beat_t translate(logic [31:0] a);
    out_beat_t r;
    int        n;
    logic [31:0] rel;
    r = '0;
    if (con_q == CON_NES) begin
      if (a >= 32'h800 && a < 32'h2000) a &= 32'h7ff;
    end else if (con_q == CON_GBC) begin
      if (a >= 32'he000 && a <= 32'hfdff) a -= 32'h2000;
    end
    if (count_q != 0) begin
      n = (count_q > MaxDesc) ? MaxDesc : count_q;
      case (con_q)
        CON_GBA: a += (a < 32'h8000) ? 32'h3000000 : (32'h2000000 - 32'h8000);
        CON_PCE: begin
          if (a < 32'h2000) a += 32'h1f0000;
          else if (a < 32'h12000) a += 32'h100000 - 32'h2000;
          else if (a < 32'h42000) a += 32'h0d0000 - 32'h12000;
          else a += 32'h1ee000 - 32'h42000;
        end
        CON_SNES: a += (a < 32'h20000) ? 32'h7e0000 : (32'h6000 - 32'h20000);
        default: ;
      endcase
      for (int i = 0; i < n; i++) begin
        if (((base_m[i] ^ a) & sel_m[i]) == 0) begin
          rel = squeeze((a - base_m[i]) & keep_m[i], disc_m[i]);
          if (rel >= len_m[i]) rel -= highest_bit(rel);
          rel += offs_m[i];
          if (backed_m[i]) begin
            r.found = 1'b1;
            r.region_index = i[3:0];
            r.region_offset = rel;
          end
          break;
        end
      end
    end else begin
      r.source_kind = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (a < size_q[i]) begin
          r.found = 1'b1;
          r.region_index = i[3:0];
          r.region_offset = a;
          break;
        end
        if (i == 0 && con_q == CON_NES) a -= 32'h6000;
        else a -= size_q[i];
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      con_q <= CON_OTHER;
      count_q <= '0;
      for (int i = 0; i < 4; i++) size_q[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONSOLE: con_q <= cfg_data[2:0];
          CFG_COUNT: count_q <= cfg_data[4:0];
          CFG_SYS: size_q[0] <= cfg_data;
          CFG_SAVE: size_q[1] <= cfg_data;
          CFG_VIDEO: size_q[2] <= cfg_data;
          CFG_CLOCK: size_q[3] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_beat.opcode == OP_WRITE) begin
          case (in_beat.field_select)
            FLD_BASE: base_m[in_beat.entry_index] = in_beat.field_value;
            FLD_SELECT: sel_m[in_beat.entry_index] = in_beat.field_value;
            FLD_DISC: disc_m[in_beat.entry_index] = in_beat.field_value;
            FLD_KEEP: keep_m[in_beat.entry_index] = in_beat.field_value;
            FLD_LENGTH: len_m[in_beat.entry_index] = in_beat.field_value;
            FLD_OFFSET: offs_m[in_beat.entry_index] = in_beat.field_value;
            FLD_BACKED: backed_m[in_beat.entry_index] = in_beat.field_value[0];
            default: ;
          endcase
        end else begin
          translations_due.push_back(translate(in_beat.guest_address));
        end
      end
      if (out_valid && !out_stall) begin
        if (translations_due.size() == 0) begin
          report("unexpected result", out_beat.region_offset, 32'd0);
        end else begin
          want = translations_due.pop_front();
          if (out_beat.found !== want.found)
            report("found", 32'(out_beat.found), 32'(want.found));
          if (out_beat.source_kind !== want.source_kind)
            report("source_kind", 32'(out_beat.source_kind), 32'(want.source_kind));
          if (out_beat.region_index !== want.region_index)
            report("region_index", 32'(out_beat.region_index), 32'(want.region_index));
          if (out_beat.region_offset !== want.region_offset)
            report("region_offset", out_beat.region_offset, want.region_offset);
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Stimulus top for the descriptor address translator testbench.
// Drives beats and config writes; dat_checker does prediction; depends on dat_pkg.
`timescale 1ns / 1ps
module tb;
  import dat_pkg::*;

  // A descriptor scan of all 16 slots with a full 32-bit squeeze is the longest
  // item; receiver stalls add more. This bound lies far beyond it.
  localparam int IdleLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  // Percent of cycles in which the sender idles and the receiver stalls.
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  // Slots loaded so far; translations only scan written slots.
  int          loaded_slots = 0;

  always #4 clk = ~clk;

  descriptor_address_translator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dat_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random; a new decision is made at each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // The watchdog counts cycles in which no beat of any channel is accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one input beat and hold it until accepted. Valid is lowered
  // only when an idle gap follows or the caller pauses, so back-to-back
  // beats keep it high.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic translate_addr(logic [31:0] a);
    in_beat_t b;
    b = '0;
    b.opcode = OP_TRANSLATE;
    b.guest_address = a;
    // Unused fields still carry random bits.
    b.entry_index = 4'($urandom);
    b.field_select = 3'($urandom);
    b.field_value = $urandom;
    send_beat(b);
  endtask

  task automatic write_field(logic [3:0] slot, logic [2:0] fld, logic [31:0] v);
    in_beat_t b;
    b = '0;
    b.opcode = OP_WRITE;
    b.guest_address = $urandom;
    b.entry_index = slot;
    b.field_select = fld;
    b.field_value = v;
    send_beat(b);
  endtask

  // Registers change only when the block is idle: all results are back,
  // plus a pause that covers a trailing descriptor write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a descriptor slot with random but sensible fields. Small select
  // masks make matches common.
  task automatic load_slot(int s);
    logic [31:0] sel;
    logic [3:0]  slot;
    slot = 4'(s);
    sel = $urandom & ~(32'hffffffff >> $urandom_range(32, 8));
    if ($urandom_range(3) == 0) sel = $urandom;
    write_field(slot, FLD_BASE, $urandom & ~(32'hffffffff >> $urandom_range(24, 8)));
    write_field(slot, FLD_SELECT, sel);
    write_field(slot, FLD_DISC,
                ($urandom_range(2) == 0) ? $urandom : ($urandom & 32'h0000f0f0));
    write_field(slot, FLD_KEEP, ($urandom_range(1) == 0) ? 32'hffffffff : $urandom);
    write_field(slot, FLD_LENGTH,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h10000));
    write_field(slot, FLD_OFFSET, $urandom);
    write_field(slot, FLD_BACKED, ($urandom_range(4) == 0) ? 32'hfffffffe : $urandom | 32'h1);
  endtask

  function automatic logic [31:0] random_addr();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h2fff);
      2: return $urandom_range(32'hffff, 32'hd000);
      3: return $urandom_range(32'h50000);
      default: return $urandom & 32'h00ffffff;
    endcase
  endfunction

  initial begin
    int items;
    int n;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fallback path with the other, NES and GBC consoles and size extremes.
    write_reg(CFG_SYS, 32'h800);
    write_reg(CFG_SAVE, 32'h2000);
    write_reg(CFG_VIDEO, 32'h0);
    write_reg(CFG_CLOCK, 32'hffffffff);
    translate_addr(32'h0);
    translate_addr(32'h7ff);
    translate_addr(32'h800);
    translate_addr(32'hffffffff);
    write_reg(CFG_CONSOLE, 32'(CON_NES));
    translate_addr(32'h800);
    translate_addr(32'h1fff);
    translate_addr(32'h2000);
    translate_addr(32'h6800);
    write_reg(CFG_CONSOLE, 32'(CON_GBC));
    translate_addr(32'he000);
    translate_addr(32'hfdff);
    translate_addr(32'hfe00);
    write_reg(CFG_CLOCK, 32'h0);
    translate_addr(32'hffffffff);

    // Directed: descriptor path. Slot 0 matches everything with a full
    // squeeze; later slot 0 is made unbacked.
    write_field(4'd0, FLD_BASE, 32'h0);
    write_field(4'd0, FLD_SELECT, 32'h0);
    write_field(4'd0, FLD_DISC, 32'hffffffff);
    write_field(4'd0, FLD_KEEP, 32'hffffffff);
    write_field(4'd0, FLD_LENGTH, 32'h0);
    write_field(4'd0, FLD_OFFSET, 32'hffffffff);
    write_field(4'd0, FLD_BACKED, 32'h1);
    write_field(4'd0, 3'd7, 32'h12345678);   // unknown field is ignored
    loaded_slots = 1;
    write_reg(CFG_COUNT, 32'h1);
    translate_addr(32'hffffffff);
    write_field(4'd0, FLD_DISC, 32'h0);
    write_field(4'd0, FLD_LENGTH, 32'h100);
    translate_addr(32'h1234);
    translate_addr(32'h80);
    write_field(4'd0, FLD_BACKED, 32'h0);
    translate_addr(32'h80);

    // Random phases: each picks idling, console, count, region sizes and table contents.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0; stall_pct = 0; end
        1: begin send_gap_pct = 48; stall_pct = 0; end
        2: begin send_gap_pct = 0; stall_pct = 48; end
        default: begin send_gap_pct = 8; stall_pct = 8; end
      endcase
      n = $urandom_range(16, 1);
      for (int s = 0; s < n; s++) load_slot(s);
      if (n > loaded_slots) loaded_slots = n;
      write_reg(CFG_CONSOLE, $urandom_range(7));
      // Counts above the table clamp; only allowed once every slot is loaded.
      if (loaded_slots == MaxDesc && $urandom_range(2) == 0)
        write_reg(CFG_COUNT, $urandom_range(31, 16));
      else if (phase % 3 == 2)
        write_reg(CFG_COUNT, 32'h0);
      else
        write_reg(CFG_COUNT, $urandom_range(loaded_slots, 1));
      write_reg(CFG_SYS, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h10000));
      write_reg(CFG_SAVE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h10000));
      write_reg(CFG_VIDEO, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h10000));
      write_reg(CFG_CLOCK, ($urandom_range(3) == 0) ? 32'hffffffff : $urandom);
      items = 0;
      while (items < 30) begin
        if ($urandom_range(9) == 0) begin
          // Stray writes: ignored fields, or rewrites of loaded slots.
          if ($urandom_range(1) == 0)
            write_field(4'($urandom), 3'd7, $urandom);
          else
            write_field(4'($urandom_range(loaded_slots - 1)), 3'($urandom_range(6)),
                        $urandom);
        end else begin
          translate_addr(random_addr());
          items++;
        end
      end
    end

    send_gap_pct = 0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
